FILE: src/ocj_pkg.sv
// Shared constants, command and slot state codes, and types for the journal.
// No dependencies; every other file in src imports this package.
package ocj_pkg;

   localparam int SLOT_DEPTH = 32;
   localparam int ADDR_W     = $clog2(SLOT_DEPTH);
   localparam int SEQ_W      = 6;
   localparam int ROW_W      = 32;
   localparam int CMD_W      = 2;
   localparam int ST_W       = 2;
   localparam int CSR_IDX_W  = 2;

   // command codes
   localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RESOLVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SCAN    = 2'd2;
   localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd3;

   // slot state codes
   localparam logic [ST_W-1:0] SLOT_RESERVED  = 2'd0;
   localparam logic [ST_W-1:0] SLOT_COMMITTED = 2'd1;
   localparam logic [ST_W-1:0] SLOT_ABORTED   = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_LIMIT  = 2'd1;

   // write port of the slot store
   typedef struct packed {
      logic              en_state;
      logic              en_rows;
      logic [ADDR_W-1:0] addr;
      logic [ST_W-1:0]   state;
      logic [ROW_W-1:0]  rows;
   } ocj_wr_type;

   // result of the shared row unit
   typedef struct packed {
      logic             over;
      logic [ROW_W-1:0] sum;
   } ocj_alu_res_type;

   // one result transaction
   typedef struct packed {
      logic             ok;
      logic [SEQ_W-1:0] seq;
      logic [ST_W-1:0]  slot_state;
      logic [SEQ_W-1:0] thru_seq;
      logic             blocked;
      logic             limit_hit;
      logic [ROW_W-1:0] committed_rows;
      logic             start_error;
      logic [SEQ_W-1:0] slot_count;
      logic [ROW_W-1:0] row_count;
      logic             last;
   } ocj_rsp_type;

endpackage

FILE: src/ocj_store.sv
// Slot store: state and row count of each slot, one write and one read port.
// Depends on ocj_pkg. Read data is registered; contents have no reset.
module ocj_store (
   input  logic                        clock,
   input  ocj_pkg::ocj_wr_type         wr,
   input  logic [ocj_pkg::ADDR_W-1:0]  rd_addr,
   output logic [ocj_pkg::ST_W-1:0]    rd_state,
   output logic [ocj_pkg::ROW_W-1:0]   rd_rows
);
   import ocj_pkg::*;

   logic [ST_W-1:0]  state_mem [SLOT_DEPTH];
   logic [ROW_W-1:0] rows_mem  [SLOT_DEPTH];
   logic [ST_W-1:0]  rd_state_ff;
   logic [ROW_W-1:0] rd_rows_ff;

   // write slot fields
   always_ff @(posedge clock) begin
      if (wr.en_state) begin
         state_mem[wr.addr] <= wr.state;
      end
      if (wr.en_rows) begin
         rows_mem[wr.addr] <= wr.rows;
      end
   end

   // read every cycle, old data on a same-address write
   always_ff @(posedge clock) begin
      rd_state_ff <= state_mem[rd_addr];
      rd_rows_ff  <= rows_mem[rd_addr];
   end

   assign rd_state = rd_state_ff;
   assign rd_rows  = rd_rows_ff;

endmodule

FILE: src/ocj_alu.sv
// Shared row unit: limit-minus-total headroom compare and total-plus-rows add.
// Depends on ocj_pkg. Used for reserve room checks and scan or query sums.
module ocj_alu (
   input  logic [ocj_pkg::ROW_W-1:0] limit_val,
   input  logic [ocj_pkg::ROW_W-1:0] total_val,
   input  logic [ocj_pkg::ROW_W-1:0] add_val,
   output ocj_pkg::ocj_alu_res_type  res
);
   import ocj_pkg::*;

   logic [ROW_W:0] room;

   // headroom with borrow; a borrow means no room at all
   assign room     = {1'b0, limit_val} - {1'b0, total_val};
   assign res.over = room[ROW_W] ? (add_val != '0) : (add_val > room[ROW_W-1:0]);
   assign res.sum  = total_val + add_val;

endmodule

FILE: src/ordered_completion_journal.sv
// Append-only journal of numbered slots; depends on ocj_pkg, ocj_store, ocj_alu.
// Reserve and resolve pass through their work state (S_RESV or S_RSLV) into the
// registered response. A scan or query walks one slot per cycle through the store
// read port, a scan only while the response output is free. One transaction is in
// work at a time and a stalled result holds the sequencer.
// Reset (synchronous) empties the journal, sets slot_limit to 32 and row_limit to all
// ones; no clearing pass is needed since only written slots are ever read.
module ordered_completion_journal (
   input  logic                            clock,
   input  logic                            reset,
   // configuration
   input  logic                            csr_we,
   input  logic [ocj_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ocj_pkg::ROW_W-1:0]       csr_wdata,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ocj_pkg::CMD_W-1:0]       req_cmd,
   input  logic [ocj_pkg::ROW_W-1:0]       req_row_total,
   input  logic [ocj_pkg::SEQ_W-1:0]       req_slot_seq,
   input  logic [ocj_pkg::ST_W-1:0]        req_target_state,
   input  logic [ocj_pkg::SEQ_W-1:0]       req_after_seq,
   input  logic [ocj_pkg::SEQ_W-1:0]       req_scan_slot_cap,
   input  logic [ocj_pkg::ROW_W-1:0]       req_scan_row_cap,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_ok,
   output logic [ocj_pkg::SEQ_W-1:0]       rsp_seq,
   output logic [ocj_pkg::ST_W-1:0]        rsp_slot_state,
   output logic [ocj_pkg::SEQ_W-1:0]       rsp_thru_seq,
   output logic                            rsp_blocked,
   output logic                            rsp_limit_hit,
   output logic [ocj_pkg::ROW_W-1:0]       rsp_committed_rows,
   output logic                            rsp_start_error,
   output logic [ocj_pkg::SEQ_W-1:0]       rsp_slot_count,
   output logic [ocj_pkg::ROW_W-1:0]       rsp_row_count,
   output logic                            rsp_last
);
   import ocj_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RESV = 2'd1;
   localparam logic [1:0] S_RSLV = 2'd2;
   localparam logic [1:0] S_WALK = 2'd3;

   localparam logic [SEQ_W-1:0] DEPTH_SEQ = SEQ_W'(SLOT_DEPTH);

   logic [1:0]       state_ff, state_in;
   logic [SEQ_W-1:0] slot_limit_ff;
   logic [ROW_W-1:0] row_limit_ff;
   logic [SEQ_W-1:0] used_ff, used_in;
   logic [ROW_W-1:0] held_ff, held_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ocj_rsp_type      rsp_ff, rsp_in;

   // transaction fields held during the work
   logic [CMD_W-1:0] cmd_ff;
   logic [ROW_W-1:0] row_total_ff;
   logic [SEQ_W-1:0] seq_ff;
   logic [ST_W-1:0]  tgt_ff;
   logic [SEQ_W-1:0] scap_ff;
   logic [ROW_W-1:0] rcap_ff;

   // walk registers
   logic [SEQ_W-1:0] idx_ff, idx_in;
   logic [SEQ_W-1:0] taken_ff, taken_in;
   logic [SEQ_W-1:0] thru_ff, thru_in;
   logic [ROW_W-1:0] sum_ff, sum_in;

   logic             accept;
   logic             out_free;
   logic             load;
   logic [SEQ_W-1:0] eff_limit;
   ocj_wr_type       wr;
   logic [ST_W-1:0]  rd_state;
   logic [ROW_W-1:0] rd_rows;
   logic [ROW_W-1:0] alu_limit, alu_total, alu_add;
   ocj_alu_res_type  alu_res;
   ocj_rsp_type      blank;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign eff_limit = (slot_limit_ff < DEPTH_SEQ) ? slot_limit_ff : DEPTH_SEQ;

   ocj_store u_store (
      .clock    (clock),
      .wr       (wr),
      .rd_addr  (idx_in[ADDR_W-1:0]),
      .rd_state (rd_state),
      .rd_rows  (rd_rows)
   );

   // route the shared unit: reserve room check, or scan and query sums
   always_comb begin
      if (state_ff == S_RESV) begin
         alu_limit = row_limit_ff;
         alu_total = held_ff;
         alu_add   = row_total_ff;
      end else begin
         alu_limit = rcap_ff;
         alu_total = sum_ff;
         alu_add   = rd_rows;
      end
   end

   ocj_alu u_alu (
      .limit_val (alu_limit),
      .total_val (alu_total),
      .add_val   (alu_add),
      .res       (alu_res)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      used_in  = used_ff;
      held_in  = held_ff;
      idx_in   = idx_ff;
      taken_in = taken_ff;
      thru_in  = thru_ff;
      sum_in   = sum_ff;
      rsp_in   = rsp_ff;
      load     = 1'b0;
      wr       = '0;

      blank            = '0;
      blank.slot_count = used_ff;
      blank.row_count  = held_ff;
      blank.last       = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  CMD_RESERVE: begin
                     state_in = S_RESV;
                  end
                  CMD_RESOLVE: begin
                     idx_in   = req_slot_seq - SEQ_W'(1);
                     state_in = S_RSLV;
                  end
                  default: begin
                     idx_in   = req_after_seq;
                     thru_in  = req_after_seq;
                     taken_in = '0;
                     sum_in   = '0;
                     state_in = S_WALK;
                  end
               endcase
            end
         end

         S_RESV: begin
            if (out_free) begin
               load   = 1'b1;
               rsp_in = blank;
               if (row_total_ff != '0 && used_ff < eff_limit && !alu_res.over) begin
                  wr.en_state       = 1'b1;
                  wr.en_rows        = 1'b1;
                  wr.addr           = used_ff[ADDR_W-1:0];
                  wr.state          = SLOT_RESERVED;
                  wr.rows           = row_total_ff;
                  used_in           = used_ff + SEQ_W'(1);
                  held_in           = alu_res.sum;
                  rsp_in.ok         = 1'b1;
                  rsp_in.seq        = used_in;
                  rsp_in.slot_count = used_in;
                  rsp_in.row_count  = alu_res.sum;
               end
               state_in = S_IDLE;
            end
         end

         S_RSLV: begin
            if (out_free) begin
               load   = 1'b1;
               rsp_in = blank;
               if (seq_ff != '0 && seq_ff <= used_ff &&
                   (tgt_ff == SLOT_COMMITTED || tgt_ff == SLOT_ABORTED)) begin
                  if (rd_state == SLOT_RESERVED) begin
                     wr.en_state = 1'b1;
                     wr.addr     = idx_ff[ADDR_W-1:0];
                     wr.state    = tgt_ff;
                     rsp_in.ok   = 1'b1;
                  end else begin
                     rsp_in.ok = (rd_state == tgt_ff);
                  end
               end
               state_in = S_IDLE;
            end
         end

         S_WALK: begin
            if (idx_ff > used_ff) begin
               // start lies beyond the latest sequence
               if (out_free) begin
                  load               = 1'b1;
                  rsp_in             = blank;
                  rsp_in.start_error = 1'b1;
                  state_in           = S_IDLE;
               end
            end else if (cmd_ff == CMD_QUERY) begin
               if (idx_ff < used_ff) begin
                  if (rd_state == SLOT_COMMITTED) begin
                     sum_in = alu_res.sum;
                  end
                  idx_in = idx_ff + SEQ_W'(1);
               end else if (out_free) begin
                  load                  = 1'b1;
                  rsp_in                = blank;
                  rsp_in.committed_rows = sum_ff;
                  state_in              = S_IDLE;
               end
            end else if (out_free) begin
               // scan: emit one slot transaction, or the summary
               load                  = 1'b1;
               rsp_in                = blank;
               rsp_in.thru_seq       = thru_ff;
               rsp_in.committed_rows = sum_ff;
               if (idx_ff == used_ff) begin
                  state_in = S_IDLE;
               end else if (rd_state == SLOT_RESERVED) begin
                  rsp_in.blocked = 1'b1;
                  state_in       = S_IDLE;
               end else if (taken_ff >= scap_ff ||
                            (rd_state == SLOT_COMMITTED && alu_res.over)) begin
                  rsp_in.limit_hit = 1'b1;
                  state_in         = S_IDLE;
               end else begin
                  rsp_in.last           = 1'b0;
                  rsp_in.seq            = idx_ff + SEQ_W'(1);
                  rsp_in.slot_state     = rd_state;
                  rsp_in.thru_seq       = idx_ff + SEQ_W'(1);
                  rsp_in.committed_rows = (rd_state == SLOT_COMMITTED) ? rd_rows : '0;
                  taken_in = taken_ff + SEQ_W'(1);
                  thru_in  = idx_ff + SEQ_W'(1);
                  sum_in   = (rd_state == SLOT_COMMITTED) ? alu_res.sum : sum_ff;
                  idx_in   = idx_ff + SEQ_W'(1);
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // output register: load when free, drop once taken
      if (load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_ff       <= '0;
         held_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         slot_limit_ff <= DEPTH_SEQ;
         row_limit_ff  <= '1;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_SLOT_LIMIT: slot_limit_ff <= csr_wdata[SEQ_W-1:0];
               CSR_ROW_LIMIT:  row_limit_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload and walk registers
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      taken_ff <= taken_in;
      thru_ff  <= thru_in;
      sum_ff   <= sum_in;
      rsp_ff   <= rsp_in;
      if (accept) begin
         cmd_ff       <= req_cmd;
         row_total_ff <= req_row_total;
         seq_ff       <= req_slot_seq;
         tgt_ff       <= req_target_state;
         scap_ff      <= req_scan_slot_cap;
         rcap_ff      <= req_scan_row_cap;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ff.ok;
   assign rsp_seq            = rsp_ff.seq;
   assign rsp_slot_state     = rsp_ff.slot_state;
   assign rsp_thru_seq       = rsp_ff.thru_seq;
   assign rsp_blocked        = rsp_ff.blocked;
   assign rsp_limit_hit      = rsp_ff.limit_hit;
   assign rsp_committed_rows = rsp_ff.committed_rows;
   assign rsp_start_error    = rsp_ff.start_error;
   assign rsp_slot_count     = rsp_ff.slot_count;
   assign rsp_row_count      = rsp_ff.row_count;
   assign rsp_last           = rsp_ff.last;

endmodule
